### rtl/mts_pkg.sv
package mts_pkg;

    // Stack geometry
    localparam int STACK_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    // Field widths of the beats
    localparam int DATA_W  = 32;
    localparam int DEPTH_W = 7;

    typedef enum logic {
        ACT_PUSH = 1'b0,
        ACT_POP  = 1'b1
    } t_action;

    // One stack entry: the value and the running minimum at that depth
    typedef struct packed {
        logic signed [DATA_W-1:0] min_value;
        logic signed [DATA_W-1:0] top_value;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Request from the controller to the entry memory
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        t_entry            wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

    // One result beat
    typedef struct packed {
        logic signed [DATA_W-1:0] top_value;
        logic signed [DATA_W-1:0] min_value;
        logic [DEPTH_W-1:0]       depth;
        logic                     error;
    } t_result;

endpackage

### rtl/mts_if.sv
interface mts_in_if;
    import mts_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     action;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

interface mts_out_if;
    import mts_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] top_value;
    logic signed [DATA_W-1:0] min_value;
    logic [DEPTH_W-1:0]       depth;
    logic                     error;

    modport source (output valid, output top_value, output min_value, output depth,
                    output error, input ready);
    modport sink   (input valid, input top_value, input min_value, input depth,
                    input error, output ready);
endinterface

### rtl/mts_ram.sv
module mts_ram #(
    parameter int DEPTH  = 64,
    parameter int WIDTH  = 64,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/mts_ctrl.sv
module mts_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mts_in_if.sink            i_in,
    mts_out_if.source         o_out,
    output mts_pkg::t_ram_req o_ram_req,
    input  mts_pkg::t_entry   i_ram_rdata
);
    import mts_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    t_state                   r_state;
    logic [CNT_W-1:0]         r_count, n_count;
    logic signed [DATA_W-1:0] r_top, n_top;
    logic signed [DATA_W-1:0] r_min, n_min;
    logic                     r_res_valid;
    t_result                  r_res;
    logic                     r_o_valid;
    t_result                  r_o;

    logic                     in_beat;
    logic                     out_free;
    logic                     done;
    logic                     go_read;
    logic                     err;
    logic                     is_empty;
    logic                     is_full;
    logic [CNT_W-1:0]         rd_idx;
    t_result                  n_res;

    // Take a new beat only when idle and the pending slot is free
    assign i_in.ready = (r_state == S_IDLE) && !r_res_valid;
    assign in_beat    = i_in.valid && i_in.ready;
    assign out_free   = !r_o_valid || o_out.ready;
    assign is_empty   = (r_count == '0);
    assign is_full    = (r_count == CNT_W'(STACK_DEPTH));
    assign rd_idx     = r_count - CNT_W'(2);

    // Decide the operation and the new top registers
    always_comb begin
        n_count = r_count;
        n_top   = r_top;
        n_min   = r_min;
        done    = 1'b0;
        go_read = 1'b0;
        err     = 1'b0;
        o_ram_req.we    = 1'b0;
        o_ram_req.re    = 1'b0;
        o_ram_req.waddr = r_count[ADDR_W-1:0];
        o_ram_req.raddr = rd_idx[ADDR_W-1:0];

        if (r_state == S_READ) begin
            // New top entry comes back from memory
            n_top = i_ram_rdata.top_value;
            n_min = i_ram_rdata.min_value;
            done  = 1'b1;
        end else if (in_beat) begin
            done = 1'b1;
            unique case (t_action'(i_in.action))
                ACT_PUSH: begin
                    if (is_full) begin
                        err = 1'b1;
                    end else begin
                        if (is_empty || (i_in.value < r_min)) begin
                            n_min = i_in.value;
                        end
                        n_top        = i_in.value;
                        n_count      = r_count + CNT_W'(1);
                        o_ram_req.we = 1'b1;
                    end
                end
                ACT_POP: begin
                    if (is_empty) begin
                        err = 1'b1;
                    end else begin
                        n_count = r_count - CNT_W'(1);
                        if (r_count == CNT_W'(1)) begin
                            n_top = '0;
                            n_min = '0;
                        end else begin
                            // Fetch the entry that becomes the top
                            o_ram_req.re = 1'b1;
                            go_read      = 1'b1;
                            done         = 1'b0;
                        end
                    end
                end
            endcase
        end

        o_ram_req.wdata.min_value = n_min;
        o_ram_req.wdata.top_value = i_in.value;

        n_res.top_value = n_top;
        n_res.min_value = n_min;
        n_res.depth     = DEPTH_W'(n_count);
        n_res.error     = err;
    end

    // Hold state, top registers and the result slots
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_top       <= '0;
            r_min       <= '0;
            r_res_valid <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            r_count <= n_count;
            r_top   <= n_top;
            r_min   <= n_min;
            r_state <= go_read ? S_READ : S_IDLE;

            if (done && out_free) begin
                r_o       <= n_res;
                r_o_valid <= 1'b1;
            end else if (r_res_valid && out_free) begin
                r_o         <= r_res;
                r_o_valid   <= 1'b1;
                r_res_valid <= 1'b0;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end

            // Park the result while the output beat is stalled
            if (done && !out_free) begin
                r_res       <= n_res;
                r_res_valid <= 1'b1;
            end
        end
    end

    assign o_out.valid     = r_o_valid;
    assign o_out.top_value = r_o.top_value;
    assign o_out.min_value = r_o.min_value;
    assign o_out.depth     = r_o.depth;
    assign o_out.error     = r_o.error;

endmodule

### rtl/min_tracking_stack_unit.sv
// Min-tracking stack: one push or pop per input beat, one result beat each.
// Push, refused operations and a pop that empties the stack: the result goes
// to the output register, or the pending slot while the output is stalled;
// 1 beat/cycle while the output is not stalled. Pop to a depth of one or more:
// the result waits for the registered read of the entry memory that refills
// the top value and minimum registers; input is held off in the read state.
// Synchronous active-low reset empties the stack; the entry memory is not
// cleared and holds no meaning above the current depth.
module min_tracking_stack_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mts_in_if.sink    i_in,
    mts_out_if.source o_out
);
    import mts_pkg::*;

    t_ram_req            ram_req;
    t_entry              ram_rdata;
    logic [ENTRY_W-1:0]  ram_rdata_raw;

    mts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_out       (o_out),
        .o_ram_req   (ram_req),
        .i_ram_rdata (ram_rdata)
    );

    mts_ram #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (ENTRY_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_re    (ram_req.re),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata_raw)
    );

    assign ram_rdata = ram_rdata_raw;

endmodule

### rtl/mts_checker.sv
module mts_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_valid,
    input logic                       i_ready,
    input logic signed [31:0]         i_top_value,
    input logic signed [31:0]         i_min_value,
    input logic [6:0]                 i_depth,
    input logic                       i_error
);
    import mts_pkg::*;

    localparam logic [DEPTH_W-1:0] FULL = DEPTH_W'(STACK_DEPTH);

    // Stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_top_value) && $stable(i_min_value)
            && $stable(i_depth) && $stable(i_error))
        else $error("result beat changed while stalled");

    // Refused operations only happen on an empty or full stack
    a_err_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_error |-> (i_depth == '0) || (i_depth == FULL))
        else $error("error flagged at a middle depth");

    // Empty stack reads zero
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_depth == '0) |-> (i_top_value == '0) && (i_min_value == '0))
        else $error("empty stack shows nonzero top or minimum");

    // Minimum never exceeds the top value
    a_min_le_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_depth != '0) |-> i_min_value <= i_top_value)
        else $error("minimum above top value");

    // Depth stays in range
    a_depth_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> i_depth <= FULL)
        else $error("depth beyond stack size");

endmodule

bind min_tracking_stack_unit mts_checker u_mts_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (o_out.valid),
    .i_ready     (o_out.ready),
    .i_top_value (o_out.top_value),
    .i_min_value (o_out.min_value),
    .i_depth     (o_out.depth),
    .i_error     (o_out.error)
);
